/* rtl/core/bbe_pkg.sv */
// Shared types, constants and alphabet functions for the base64 / base32hex encoder.
// No dependencies; imported by every module of the encoder.
package bbe_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [6:0] PAD_CHAR = 7'h3D;

   localparam logic ENC_BASE64    = 1'b0;
   localparam logic ENC_BASE32HEX = 1'b1;

   typedef struct packed {
      logic [39:0] bits;
      logic        b32;
      logic [3:0]  sig;
      logic        last;
   } group_entry_type;

   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] r;
      if (v < 6'd26) begin
         r = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         r = 7'h61 + {1'b0, v} - 7'd26;
      end else if (v < 6'd62) begin
         r = 7'h30 + {1'b0, v} - 7'd52;
      end else if (v == 6'd62) begin
         r = 7'h2B;
      end else begin
         r = 7'h2F;
      end
      return r;
   endfunction

   function automatic logic [6:0] b32h_char(input logic [4:0] v);
      logic [6:0] r;
      if (v < 5'd10) begin
         r = 7'h30 + {2'b0, v};
      end else begin
         r = 7'h41 + {2'b0, v} - 7'd10;
      end
      return r;
   endfunction

   function automatic logic [3:0] b32_sig(input logic [2:0] n);
      logic [3:0] r;
      unique case (n)
         3'd1:    r = 4'd2;
         3'd2:    r = 4'd4;
         3'd3:    r = 4'd5;
         3'd4:    r = 4'd7;
         3'd5:    r = 4'd8;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/bbe_front.sv */
// Front end: takes request bytes, packs them into the current group, pushes finished groups.
// Depends on bbe_pkg.
module bbe_front
   import bbe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            encoding,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_data_byte,
   input  logic            req_last_byte,
   input  logic            q_full,
   output logic            q_push,
   output group_entry_type q_wr_entry
);

   logic [39:0] bits_ff;
   logic [39:0] bits_in;
   logic [2:0]  count_ff;
   logic [2:0]  count_in;
   logic [2:0]  gsize;
   logic [2:0]  pos;
   logic [2:0]  pos_n;
   logic [5:0]  shift;
   logic [39:0] merged;
   logic        emit;
   logic        accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      gsize = (encoding == ENC_BASE32HEX) ? 3'd5 : 3'd3;
      pos   = (count_ff >= gsize) ? gsize - 3'd1 : count_ff;
      shift = (encoding == ENC_BASE32HEX) ? 6'd32 - {pos, 3'b000} : 6'd16 - {pos, 3'b000};
      merged = (bits_ff & ~(40'hFF << shift)) | ({32'b0, req_data_byte} << shift);
      pos_n = pos + 3'd1;
      emit  = (pos_n >= gsize) || req_last_byte;

      q_wr_entry.bits = merged;
      q_wr_entry.b32  = encoding;
      q_wr_entry.sig  = (encoding == ENC_BASE32HEX) ? b32_sig(pos_n) : {1'b0, pos_n} + 4'd1;
      q_wr_entry.last = req_last_byte;
      q_push = accept && emit;

      bits_in  = bits_ff;
      count_in = count_ff;
      if (accept) begin
         bits_in  = emit ? 40'b0 : merged;
         count_in = emit ? 3'd0 : pos_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= 40'b0;
         count_ff <= 3'd0;
      end else begin
         bits_ff  <= bits_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/core/bbe_queue.sv */
// Short group queue between front end and character serializer.
// Depends on bbe_pkg.
module bbe_queue
   import bbe_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  group_entry_type wr_entry,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output group_entry_type rd_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   group_entry_type  mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (cnt_ff == CNT_FULL);
   assign not_empty = (cnt_ff != '0);
   assign rd_entry  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* rtl/core/bbe_back.sv */
// Back end: serializes queued groups into the output register, one char per cycle unless stalled.
// Depends on bbe_pkg.
module bbe_back
   import bbe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_not_empty,
   input  group_entry_type q_rd_entry,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [6:0]      rsp_out_char,
   output logic            rsp_last_char
);

   logic [2:0]  k_ff;
   logic [2:0]  k_in;
   logic        valid_ff;
   logic        valid_in;
   logic [6:0]  char_ff;
   logic [6:0]  char_in;
   logic        last_ff;
   logic        last_in;
   logic        adv;
   logic [2:0]  k_end;
   logic [5:0]  sh;
   logic [39:0] shifted;
   logic [6:0]  sym;

   assign adv = q_not_empty && (!valid_ff || rsp_ready);

   always_comb begin
      k_end = q_rd_entry.b32 ? 3'd7 : 3'd3;
      sh = q_rd_entry.b32 ? 6'd35 - {3'b0, k_ff} * 6'd5 : 6'd18 - {3'b0, k_ff} * 6'd6;
      shifted = q_rd_entry.bits >> sh;
      if ({1'b0, k_ff} >= q_rd_entry.sig) begin
         sym = PAD_CHAR;
      end else if (q_rd_entry.b32) begin
         sym = b32h_char(shifted[4:0]);
      end else begin
         sym = b64_char(shifted[5:0]);
      end
      q_pop = adv && (k_ff == k_end);

      k_in     = k_ff;
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      if (adv) begin
         k_in     = q_pop ? 3'd0 : k_ff + 3'd1;
         valid_in = 1'b1;
         char_in  = sym;
         last_in  = q_rd_entry.last && q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

endmodule

/* rtl/core/base64_base32hex_encoder_unit.sv */
// Top level of the base64 / base32hex encoder: front end, group queue, character serializer.
// Depends on bbe_pkg, bbe_front, bbe_queue, bbe_back.
//
// Usage:
//   req_ channel carries one raw byte per request; req_last_byte flags the final byte.
//   rsp_ channel carries one ASCII character per request; rsp_last_char flags the
//   final character of the encoded string, '=' padding included.
//   csr_ channel writes the encoding bit (0 base64, 1 base32hex); csr_ready is always
//   high. Write it only while no message is in flight.
// Path: the group completed by an accepted byte is written into the group queue, and
//   its first character then goes through the output register onto rsp_.
// Throughput: the serializer puts out one character per cycle while rsp_ready is high and
//   the queue holds a group. Bytes that do not end a group are taken every cycle while
//   the group queue has room.
// Reset: clears the group in progress, the queue and the output register; the
//   encoding returns to base64.
// Stall: rsp_ holds its character while rsp_ready is low; the queue of QUEUE_DEPTH_P
//   groups fills and then req_ready drops.
module base64_base32hex_encoder_unit
   import bbe_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_encoding,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_char
);

   logic            encoding_ff;
   logic            q_full;
   logic            q_push;
   logic            q_pop;
   logic            q_not_empty;
   group_entry_type q_wr_entry;
   group_entry_type q_rd_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         encoding_ff <= ENC_BASE64;
      end else if (csr_valid && csr_ready) begin
         encoding_ff <= csr_encoding;
      end
   end

   bbe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .encoding      (encoding_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_wr_entry    (q_wr_entry)
   );

   bbe_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_entry  (q_wr_entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .rd_entry  (q_rd_entry)
   );

   bbe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_rd_entry    (q_rd_entry),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

/* rtl/core/bbe_checker.sv */
// Port-level checks for the base64 / base32hex encoder, bound to the top level.
// Depends on bbe_pkg and base64_base32hex_encoder_unit.
module bbe_checker
   import bbe_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       csr_valid,
   input logic       csr_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_out_char,
   input logic       rsp_last_char
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_char))
      else $error("rsp payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char >= 7'h2B) && (rsp_out_char <= 7'h7A))
      else $error("character outside both alphabets");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind base64_base32hex_encoder_unit bbe_checker u_bbe_checker (
   .clock         (clock),
   .reset         (reset),
   .csr_valid     (csr_valid),
   .csr_ready     (csr_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_char  (rsp_out_char),
   .rsp_last_char (rsp_last_char)
);
